FILE: hw/rtl/fpp_pkg.sv
`default_nettype none

package fpp_pkg;

    localparam int CharWidth   = 8;
    localparam int SquareWidth = 6;
    localparam int PieceWidth  = 4;
    localparam int StatusWidth = 3;
    localparam int PhaseWidth  = 3;
    localparam int CountWidth  = 4;
    localparam int ColLenWidth = 2;

    localparam logic [PhaseWidth-1:0] PH_BEFORE = 3'd0;
    localparam logic [PhaseWidth-1:0] PH_PLACE  = 3'd1;
    localparam logic [PhaseWidth-1:0] PH_GAP    = 3'd2;
    localparam logic [PhaseWidth-1:0] PH_COLOUR = 3'd3;
    localparam logic [PhaseWidth-1:0] PH_AFTER  = 3'd4;

    localparam logic [StatusWidth-1:0] ST_OK         = 3'd0;
    localparam logic [StatusWidth-1:0] ST_MISSING    = 3'd1;
    localparam logic [StatusWidth-1:0] ST_WIDTH      = 3'd2;
    localparam logic [StatusWidth-1:0] ST_RANKS      = 3'd3;
    localparam logic [StatusWidth-1:0] ST_OVERFLOW   = 3'd4;
    localparam logic [StatusWidth-1:0] ST_UNKNOWN    = 3'd5;
    localparam logic [StatusWidth-1:0] ST_INCOMPLETE = 3'd6;
    localparam logic [StatusWidth-1:0] ST_COLOUR     = 3'd7;

    localparam logic [PieceWidth-1:0] PIECE_NONE = 4'd0;

    localparam logic [CharWidth-1:0] CH_SLASH   = 8'h2F;
    localparam logic [CharWidth-1:0] CH_ONE     = 8'h31;
    localparam logic [CharWidth-1:0] CH_EIGHT   = 8'h38;
    localparam logic [CharWidth-1:0] CH_WHITE   = 8'h77;
    localparam logic [CharWidth-1:0] CH_BLACK   = 8'h62;
    localparam logic [CharWidth-1:0] CH_SPACE   = 8'h20;
    localparam logic [CharWidth-1:0] CH_TAB     = 8'h09;
    localparam logic [CharWidth-1:0] CH_CR      = 8'h0D;

    localparam logic [CountWidth-1:0] FILES_FULL = 4'd8;
    localparam logic [CountWidth-1:0] RANK_LAST  = 4'd7;
    localparam logic [CountWidth-1:0] RANK_LIMIT = 4'd8;

    typedef struct packed {
        logic                  blank;
        logic                  slash;
        logic                  digit;
        logic [CountWidth-1:0] digit_val;
        logic [PieceWidth-1:0] piece;
    } char_class_t;

    typedef struct packed {
        logic                   square_write;
        logic [SquareWidth-1:0] square_index;
        logic [PieceWidth-1:0]  piece_code;
        logic                   done_res;
        logic [StatusWidth-1:0] status;
        logic                   side_to_move;
    } result_t;

    function automatic logic [PieceWidth-1:0] piece_of(input logic [CharWidth-1:0] c);
        logic [PieceWidth-1:0] p;
        begin
            case (c)
                8'h50:   p = 4'd1;
                8'h4E:   p = 4'd2;
                8'h42:   p = 4'd3;
                8'h52:   p = 4'd4;
                8'h51:   p = 4'd5;
                8'h4B:   p = 4'd6;
                8'h70:   p = 4'd7;
                8'h6E:   p = 4'd8;
                8'h62:   p = 4'd9;
                8'h72:   p = 4'd10;
                8'h71:   p = 4'd11;
                8'h6B:   p = 4'd12;
                default: p = PIECE_NONE;
            endcase
            return p;
        end
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/fen_placement_parser.sv
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   char_in, last_byte
// out      output     out_valid / out_stall square_write, square_index, piece_code,
//                                           done_res, status, side_to_move
//
// One item per cycle while out_stall is low; each item passes through the input register,
// then through the parse logic into the result register.
// rst_n clears the parse state and both stage valids; payload registers are not reset.
// out_stall holds the result register and, through a full input register, stalls in.
`default_nettype none

module fen_placement_parser
    import fpp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [CharWidth-1:0]   char_in,
    input  wire logic                   last_byte,
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic                        square_write,
    output logic [SquareWidth-1:0]      square_index,
    output logic [PieceWidth-1:0]       piece_code,
    output logic                        done_res,
    output logic [StatusWidth-1:0]      status,
    output logic                        side_to_move
);

    logic                 s1_valid_reg;
    logic [CharWidth-1:0] s1_char_reg;
    logic                 s1_last_reg;
    logic                 out_valid_reg;
    result_t              out_reg;

    logic        s2_ready;
    logic        s1_ready;
    logic        advance;
    char_class_t cls;
    result_t     res;

    assign s2_ready = !out_valid_reg || !out_stall;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign advance  = s1_valid_reg && s2_ready;
    assign in_stall = !s1_ready;

    fpp_classify u_classify (
        .char_in (s1_char_reg),
        .cls     (cls)
    );

    fpp_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .char_in   (s1_char_reg),
        .last_byte (s1_last_reg),
        .cls       (cls),
        .res       (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_char_reg <= char_in;
            s1_last_reg <= last_byte;
        end
        if (advance)
            out_reg <= res;
    end

    assign out_valid    = out_valid_reg;
    assign square_write = out_reg.square_write;
    assign square_index = out_reg.square_index;
    assign piece_code   = out_reg.piece_code;
    assign done_res     = out_reg.done_res;
    assign status       = out_reg.status;
    assign side_to_move = out_reg.side_to_move;

endmodule

`default_nettype wire

FILE: hw/rtl/fpp_classify.sv
`default_nettype none

module fpp_classify
    import fpp_pkg::*;
(
    input  wire logic [CharWidth-1:0] char_in,
    output char_class_t               cls
);

    logic [CharWidth-1:0] digit_off;

    assign digit_off = char_in - CH_ONE + 8'd1;

    always_comb
    begin
        cls.blank     = (char_in == CH_SPACE) || ((char_in >= CH_TAB) && (char_in <= CH_CR));
        cls.slash     = (char_in == CH_SLASH);
        cls.digit     = (char_in >= CH_ONE) && (char_in <= CH_EIGHT);
        cls.digit_val = digit_off[CountWidth-1:0];
        cls.piece     = piece_of(char_in);
    end

endmodule

`default_nettype wire

FILE: hw/rtl/fpp_parser.sv
`default_nettype none

module fpp_parser
    import fpp_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 advance,
    input  wire logic [CharWidth-1:0] char_in,
    input  wire logic                 last_byte,
    input  wire char_class_t          cls,
    output result_t                   res
);

    logic [PhaseWidth-1:0]  phase_reg,   phase_next;
    logic [CountWidth-1:0]  rank_reg,    rank_next;
    logic [CountWidth-1:0]  file_reg,    file_next;
    logic [StatusWidth-1:0] err_reg,     err_next;
    logic [CharWidth-1:0]   col_ch_reg,  col_ch_next;
    logic [ColLenWidth-1:0] col_len_reg, col_len_next;

    logic [PhaseWidth-1:0]  phase_tok;
    logic [CountWidth:0]    file_sum;

    assign file_sum = {1'b0, file_reg} + {1'b0, cls.digit_val};

    always_comb
    begin
        phase_tok    = phase_reg;
        rank_next    = rank_reg;
        file_next    = file_reg;
        err_next     = err_reg;
        col_ch_next  = col_ch_reg;
        col_len_next = col_len_reg;
        res          = '0;

        if (cls.blank)
        begin
            if (phase_reg == PH_PLACE)
                phase_tok = PH_GAP;
            else if (phase_reg == PH_COLOUR)
                phase_tok = PH_AFTER;
        end
        else
        begin
            if (phase_reg == PH_BEFORE)
                phase_tok = PH_PLACE;
            else if (phase_reg == PH_GAP)
                phase_tok = PH_COLOUR;

            if (phase_tok == PH_PLACE && err_reg == ST_OK)
            begin
                if (cls.slash)
                begin
                    if (file_reg != FILES_FULL)
                        err_next = ST_WIDTH;
                    else
                    begin
                        rank_next = rank_reg + 4'd1;
                        file_next = '0;
                    end
                end
                else if (rank_reg >= RANK_LIMIT)
                    err_next = ST_RANKS;
                else if (cls.digit)
                begin
                    if (file_sum > {1'b0, FILES_FULL})
                        err_next = ST_OVERFLOW;
                    else
                        file_next = file_sum[CountWidth-1:0];
                end
                else if (cls.piece == PIECE_NONE)
                    err_next = ST_UNKNOWN;
                else if (file_reg >= FILES_FULL)
                    err_next = ST_OVERFLOW;
                else
                begin
                    res.square_write = 1'b1;
                    res.square_index = {rank_reg[2:0], file_reg[2:0]};
                    res.piece_code   = cls.piece;
                    file_next        = file_reg + 4'd1;
                end
            end
            else if (phase_tok == PH_COLOUR)
            begin
                if (col_len_reg == 2'd0)
                    col_ch_next = char_in;
                if (col_len_reg != 2'd3)
                    col_len_next = col_len_reg + 2'd1;
            end
        end

        phase_next = phase_tok;

        if (last_byte)
        begin
            res.done_res = 1'b1;
            if (phase_tok < PH_COLOUR)
                res.status = ST_MISSING;
            else if (err_next != ST_OK)
                res.status = err_next;
            else if (rank_next != RANK_LAST || file_next != FILES_FULL)
                res.status = ST_INCOMPLETE;
            else if (col_len_next == 2'd1 && col_ch_next == CH_WHITE)
                res.side_to_move = 1'b0;
            else if (col_len_next == 2'd1 && col_ch_next == CH_BLACK)
                res.side_to_move = 1'b1;
            else
                res.status = ST_COLOUR;

            phase_next   = PH_BEFORE;
            rank_next    = '0;
            file_next    = '0;
            err_next     = ST_OK;
            col_ch_next  = '0;
            col_len_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_BEFORE;
            rank_reg    <= '0;
            file_reg    <= '0;
            err_reg     <= ST_OK;
            col_ch_reg  <= '0;
            col_len_reg <= '0;
        end
        else if (advance)
        begin
            phase_reg   <= phase_next;
            rank_reg    <= rank_next;
            file_reg    <= file_next;
            err_reg     <= err_next;
            col_ch_reg  <= col_ch_next;
            col_len_reg <= col_len_next;
        end
    end

    a_reset_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        advance && last_byte |=> phase_reg == PH_BEFORE && err_reg == ST_OK
            && rank_reg == '0 && file_reg == '0)
        else $error("state not cleared after last item");

    a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg != ST_OK && !(advance && last_byte) |=> err_reg == $past(err_reg))
        else $error("held error changed");

    a_file_bound: assert property (@(posedge clk) disable iff (!rst_n)
        file_reg <= FILES_FULL && rank_reg <= RANK_LIMIT)
        else $error("rank or file counter out of range");

    a_write_on_board: assert property (@(posedge clk) disable iff (!rst_n)
        advance && res.square_write |-> rank_reg < RANK_LIMIT && file_reg < FILES_FULL
            && res.piece_code != PIECE_NONE)
        else $error("square write off the board");

endmodule

`default_nettype wire

FILE: bench/fen_placement_parser_tb.sv
`default_nettype none

module fen_placement_parser_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import fpp_pkg::*;

    localparam int CYCLE_LIMIT = 200_000;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [CharWidth-1:0]   char_in;
    logic                   last_byte;
    logic                   out_valid;
    logic                   out_stall;
    logic                   square_write;
    logic [SquareWidth-1:0] square_index;
    logic [PieceWidth-1:0]  piece_code;
    logic                   done_res;
    logic [StatusWidth-1:0] status;
    logic                   side_to_move;

    logic [PhaseWidth-1:0]  phase;
    logic [CountWidth-1:0]  ranks;
    logic [CountWidth-1:0]  files;
    logic [StatusWidth-1:0] held_status;
    logic [CharWidth-1:0]   colour_first;
    logic [ColLenWidth-1:0] colour_len;

    result_t              expected_results[$];
    logic [CharWidth-1:0] text_q[$];
    bit                   traffic_on;
    int                   mismatches;
    int                   results_checked;
    int                   bytes_sent;
    int                   strings_sent;
    int                   status_seen[8];
    int                   cycles = 0;

    fen_placement_parser u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .char_in      (char_in),
        .last_byte    (last_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .square_write (square_write),
        .square_index (square_index),
        .piece_code   (piece_code),
        .done_res     (done_res),
        .status       (status),
        .side_to_move (side_to_move)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
    end

    function automatic void clear_parse_state();
        phase        = PH_BEFORE;
        ranks        = '0;
        files        = '0;
        held_status  = ST_OK;
        colour_first = '0;
        colour_len   = '0;
    endfunction

    function automatic result_t parse_byte(input logic [CharWidth-1:0] c, input logic last);
        result_t               r;
        logic [PieceWidth-1:0] p;
        int                    reach;
        r = '0;
        r.done_res = last;
        case (c)
            "P":     p = 4'd1;
            "N":     p = 4'd2;
            "B":     p = 4'd3;
            "R":     p = 4'd4;
            "Q":     p = 4'd5;
            "K":     p = 4'd6;
            "p":     p = 4'd7;
            "n":     p = 4'd8;
            "b":     p = 4'd9;
            "r":     p = 4'd10;
            "q":     p = 4'd11;
            "k":     p = 4'd12;
            default: p = PIECE_NONE;
        endcase
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
        begin
            if (phase == PH_PLACE)
                phase = PH_GAP;
            else if (phase == PH_COLOUR)
                phase = PH_AFTER;
        end
        else
        begin
            if (phase == PH_BEFORE)
                phase = PH_PLACE;
            else if (phase == PH_GAP)
                phase = PH_COLOUR;
            if (phase == PH_PLACE && held_status == ST_OK)
            begin
                if (c == CH_SLASH)
                begin
                    if (files != FILES_FULL)
                        held_status = ST_WIDTH;
                    else
                    begin
                        ranks = ranks + 1'b1;
                        files = '0;
                    end
                end
                else if (ranks >= RANK_LIMIT)
                    held_status = ST_RANKS;
                else if (c >= CH_ONE && c <= CH_EIGHT)
                begin
                    reach = int'(files) + int'(c - CH_ONE) + 1;
                    if (reach > int'(FILES_FULL))
                        held_status = ST_OVERFLOW;
                    else
                        files = CountWidth'(reach);
                end
                else if (p == PIECE_NONE)
                    held_status = ST_UNKNOWN;
                else if (files >= FILES_FULL)
                    held_status = ST_OVERFLOW;
                else
                begin
                    r.square_write = 1'b1;
                    r.square_index = {ranks[2:0], files[2:0]};
                    r.piece_code   = p;
                    files          = files + 1'b1;
                end
            end
            else if (phase == PH_COLOUR)
            begin
                if (colour_len == '0)
                    colour_first = c;
                if (colour_len != 2'd3)
                    colour_len = colour_len + 1'b1;
            end
        end
        if (last)
        begin
            if (phase < PH_COLOUR)
                r.status = ST_MISSING;
            else if (held_status != ST_OK)
                r.status = held_status;
            else if (ranks != RANK_LAST || files != FILES_FULL)
                r.status = ST_INCOMPLETE;
            else if (colour_len == 2'd1 && colour_first == CH_WHITE)
                r.side_to_move = 1'b0;
            else if (colour_len == 2'd1 && colour_first == CH_BLACK)
                r.side_to_move = 1'b1;
            else
                r.status = ST_COLOUR;
            clear_parse_state();
        end
        return r;
    endfunction

    function automatic logic [CharWidth-1:0] random_blank();
        int pick;
        pick = $urandom_range(0, 5);
        return (pick == 5) ? CH_SPACE : CH_TAB + CharWidth'(pick);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 40)
            $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    task automatic send_byte(input logic [CharWidth-1:0] c, input logic last);
        if (traffic_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_in   <= c;
        last_byte <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expected_results.push_back(parse_byte(c, last));
        bytes_sent++;
    endtask

    task automatic send_text();
        foreach (text_q[i])
            send_byte(text_q[i], i == text_q.size() - 1);
        strings_sent++;
    endtask

    task automatic load_text(input string s);
        text_q.delete();
        for (int i = 0; i < s.len(); i++)
            text_q.push_back(s[i]);
    endtask

    task automatic make_random_text();
        logic [CharWidth-1:0] letters [12];
        string                tail;
        int                   kind;
        int                   rank_total;
        int                   width;
        int                   fill;
        int                   run;
        int                   pos;
        letters = '{"P", "N", "B", "R", "Q", "K", "p", "n", "b", "r", "q", "k"};
        tail    = " KQkq - 0 1";
        text_q.delete();
        kind = $urandom_range(0, 9);
        if (kind == 0)
        begin
            repeat ($urandom_range(1, 12))
                text_q.push_back(CharWidth'($urandom_range(0, 255)));
            return;
        end
        if ($urandom_range(0, 7) == 0)
            text_q.push_back(random_blank());
        rank_total = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 9) : 8;
        for (int r = 0; r < rank_total; r++)
        begin
            width = ($urandom_range(0, 11) == 0) ? $urandom_range(7, 9) : 8;
            fill  = 0;
            if (r > 0)
                text_q.push_back(CH_SLASH);
            while (fill < width)
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    run = $urandom_range(1, (width - fill > 8) ? 8 : width - fill);
                    text_q.push_back(CH_ONE + CharWidth'(run - 1));
                    fill += run;
                end
                else
                begin
                    text_q.push_back(letters[$urandom_range(0, 11)]);
                    fill++;
                end
            end
        end
        if ($urandom_range(0, 14) != 0)
        begin
            repeat ($urandom_range(1, 2))
                text_q.push_back(random_blank());
            case ($urandom_range(0, 9))
                0, 1, 2, 3: text_q.push_back(CH_WHITE);
                4, 5, 6, 7: text_q.push_back(CH_BLACK);
                8:          text_q.push_back(CharWidth'($urandom_range(0, 255)));
                default:
                    repeat ($urandom_range(2, 4))
                        text_q.push_back($urandom_range(0, 1) ? CH_WHITE : CH_BLACK);
            endcase
            if ($urandom_range(0, 2) == 0)
                for (int i = 0; i < tail.len(); i++)
                    text_q.push_back(tail[i]);
        end
        if (kind <= 2 && text_q.size() > 1)
        begin
            pos = $urandom_range(0, text_q.size() - 1);
            case ($urandom_range(0, 3))
                0: text_q[pos] = CharWidth'($urandom_range(0, 255));
                1: text_q.delete(pos);
                2: text_q.insert(pos, CharWidth'($urandom_range(0, 255)));
                default:
                    while (text_q.size() > pos + 1)
                        void'(text_q.pop_back());
            endcase
        end
    endtask

    task automatic test_sparse_board();
        load_text("k7/8/8/8/8/8/8/7K b");
        send_text();
    endtask

    task automatic test_bad_tokens();
        text_q = '{8'h00, CH_SPACE, 8'hFF};
        send_text();
        text_q = '{8'hFF};
        send_text();
    endtask

    task automatic test_random_strings(input int target);
        int stop_at;
        stop_at = bytes_sent + target;
        while (bytes_sent < stop_at)
        begin
            make_random_text();
            send_text();
        end
    endtask

    task automatic test_full_rate(input int target);
        traffic_on = 1'b0;
        test_random_strings(target);
    endtask

    always @(posedge clk)
    begin
        result_t want;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result, queue depth", 0, 1);
            else
            begin
                want = expected_results.pop_front();
                results_checked++;
                if (want.done_res)
                    status_seen[want.status]++;
                if (square_write !== want.square_write)
                    report_mismatch("square_write", square_write, want.square_write);
                if (square_index !== want.square_index)
                    report_mismatch("square_index", square_index, want.square_index);
                if (piece_code !== want.piece_code)
                    report_mismatch("piece_code", piece_code, want.piece_code);
                if (done_res !== want.done_res)
                    report_mismatch("done_res", done_res, want.done_res);
                if (status !== want.status)
                    report_mismatch("status", status, want.status);
                if (side_to_move !== want.side_to_move)
                    report_mismatch("side_to_move", side_to_move, want.side_to_move);
            end
        end
    end

    initial
    begin
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (traffic_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
        end
    end

    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d results outstanding",
                 cycles, expected_results.size());
        $display("fen_placement_parser test failed");
        $finish;
    end

    initial
    begin
        string tally;
        traffic_on = 1'b1;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        char_in   <= '0;
        last_byte <= 1'b0;
        clear_parse_state();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        test_sparse_board();
        test_bad_tokens();
        test_random_strings(1600);
        test_full_rate(250);

        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);

        tally = "";
        for (int s = 0; s < 8; s++)
            tally = {tally, $sformatf(" %0d", status_seen[s])};
        $display("parsed %0d strings in %0d bytes, %0d results checked, %0d mismatches",
                 strings_sent, bytes_sent, results_checked, mismatches);
        $display("final status counts, ok through bad colour:%s", tally);
        if (mismatches == 0)
            $display("fen_placement_parser test passed");
        else
            $display("fen_placement_parser test failed");
        $finish;
    end

endmodule

`default_nettype wire
